// ===== sv/tapd_pkg.sv =====
`default_nettype none
package tapd_pkg;

   // field widths
   localparam int ANGLE_W   = 32;
   localparam int GAIN_W    = 16;
   localparam int LIMIT_W   = 31;
   localparam int SCALE_W   = 8;
   localparam int CSR_W     = 31;
   localparam int CSR_IDX_W = 3;

   // serial multiplier: signed multiplicand, unsigned multiplier, one bit per cycle
   localparam int MUL_A_W     = 34;
   localparam int MUL_B_W     = 16;
   localparam int SCALE_STEPS = 8;
   localparam int PROD_W      = MUL_A_W + 1 + SCALE_STEPS;
   localparam int SAT_IN_W    = PROD_W + 1;

   localparam int CNT_W = 4;
   localparam logic [CNT_W-1:0] GAIN_LAST  = CNT_W'(MUL_B_W - 1);
   localparam logic [CNT_W-1:0] SCALE_LAST = CNT_W'(SCALE_STEPS - 1);

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_KP_X       = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_KP_Y       = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_KD_X       = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_KD_Y       = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_STEP_LIMIT = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_P_SCALE    = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_D_SCALE    = 3'd6;

   // register reset values
   localparam logic [GAIN_W-1:0]  KP_RESET    = 16'd655;
   localparam logic [GAIN_W-1:0]  KD_RESET    = 16'd655;
   localparam logic [LIMIT_W-1:0] LIMIT_RESET = 31'd13107;
   localparam logic [SCALE_W-1:0] P_SC_RESET  = 8'd2;
   localparam logic [SCALE_W-1:0] D_SC_RESET  = 8'd10;

   localparam logic FUNC_UPDATE = 1'b0;
   localparam logic FUNC_CLEAR  = 1'b1;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_P_MUL,
      ST_P_CHECK,
      ST_D_MUL,
      ST_D_END,
      ST_SP_MUL,
      ST_SP_END,
      ST_SD_MUL,
      ST_DONE
   } state_type;

   typedef enum logic [1:0] {
      RES_UPDATE,
      RES_CLEAR,
      RES_TOO_FAST
   } result_kind_type;

   typedef struct packed {
      logic take_in;
      logic clear;
      logic mul_step;
      logic chk_commit;
      logic d_end;
      logic p_end;
   } ctrl_type;

   function automatic logic signed [ANGLE_W-1:0] sat_angle(
      input logic signed [SAT_IN_W-1:0] v);
      logic [SAT_IN_W-ANGLE_W:0] top;
      logic signed [ANGLE_W-1:0] r;
      top = v[SAT_IN_W-1:ANGLE_W-1];
      if ((&top) || !(|top)) begin
         r = v[ANGLE_W-1:0];
      end else if (v[SAT_IN_W-1]) begin
         r = {1'b1, {(ANGLE_W-1){1'b0}}};
      end else begin
         r = {1'b0, {(ANGLE_W-1){1'b1}}};
      end
      return r;
   endfunction

endpackage
`default_nettype wire

// ===== sv/tapd_serial_mul.sv =====
`default_nettype none
module tapd_serial_mul #(
   parameter int AW = 34,
   parameter int BW = 16
) (
   input  wire logic                 clock,
   input  wire logic                 load,
   input  wire logic                 step,
   input  wire logic signed [AW-1:0] a,
   input  wire logic        [BW-1:0] b,
   output      logic signed [AW:0]   hi,
   output      logic        [BW-1:0] lo
);

   logic signed [AW-1:0] a_ff;
   logic        [BW-1:0] b_ff;
   logic signed [AW:0]   hi_ff;
   logic        [BW-1:0] lo_ff;
   logic signed [AW+1:0] sum;

   // add the multiplicand for the current multiplier bit, then shift right one place
   assign sum = {hi_ff[AW], hi_ff} + (b_ff[0] ? {{2{a_ff[AW-1]}}, a_ff} : '0);

   always_ff @(posedge clock) begin
      if (load) begin
         a_ff  <= a;
         b_ff  <= b;
         hi_ff <= '0;
         lo_ff <= '0;
      end else if (step) begin
         hi_ff <= sum[AW+1:1];
         lo_ff <= {sum[0], lo_ff[BW-1:1]};
         b_ff  <= {1'b0, b_ff[BW-1:1]};
      end
   end

   assign hi = hi_ff;
   assign lo = lo_ff;

endmodule
`default_nettype wire

// ===== sv/tapd_axis.sv =====
`default_nettype none
module tapd_axis (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire tapd_pkg::ctrl_type                  ctrl,
   input  wire logic signed [tapd_pkg::ANGLE_W-1:0] goal,
   input  wire logic signed [tapd_pkg::ANGLE_W-1:0] angle,
   input  wire logic        [tapd_pkg::GAIN_W-1:0]  kp,
   input  wire logic        [tapd_pkg::GAIN_W-1:0]  kd,
   input  wire logic        [tapd_pkg::LIMIT_W-1:0] step_limit,
   input  wire logic        [tapd_pkg::SCALE_W-1:0] p_scale,
   input  wire logic        [tapd_pkg::SCALE_W-1:0] d_scale,
   output      logic                                too_big,
   output      logic signed [tapd_pkg::ANGLE_W-1:0] drive
);
   import tapd_pkg::*;

   logic signed [ANGLE_W-1:0] err_ff;
   logic signed [ANGLE_W-1:0] integ_ff;
   logic signed [ANGLE_W-1:0] last_err_ff;
   logic signed [MUL_A_W-1:0] d_ff;
   logic signed [PROD_W-1:0]  pprod_ff;

   logic signed [ANGLE_W:0]   e_diff;
   logic signed [ANGLE_W-1:0] e_in;
   logic signed [ANGLE_W:0]   d_diff;
   logic signed [MUL_A_W:0]   mul_hi;
   logic        [MUL_B_W-1:0] mul_lo;
   logic                      mul_load;
   logic signed [MUL_A_W-1:0] mul_a;
   logic        [MUL_B_W-1:0] mul_b;
   logic        [MUL_A_W:0]   step_abs;
   logic signed [SAT_IN_W-1:0] integ_sum;
   logic signed [ANGLE_W-1:0] integ_new;
   logic signed [PROD_W-1:0]  mul_prod;
   logic signed [SAT_IN_W-1:0] drive_sum;

   assign e_diff = {angle[ANGLE_W-1], angle} - {goal[ANGLE_W-1], goal};
   assign e_in   = sat_angle({{(SAT_IN_W-ANGLE_W-1){e_diff[ANGLE_W]}}, e_diff});
   assign d_diff = {err_ff[ANGLE_W-1], err_ff} - {last_err_ff[ANGLE_W-1], last_err_ff};

   // the proportional step is the high word after the gain pass
   assign step_abs = mul_hi[MUL_A_W] ? (~mul_hi + 1'b1) : mul_hi;
   assign too_big  = step_abs > {{(MUL_A_W+1-LIMIT_W){1'b0}}, step_limit};

   assign integ_sum = {{(SAT_IN_W-ANGLE_W){integ_ff[ANGLE_W-1]}}, integ_ff}
                    + {{(SAT_IN_W-MUL_A_W-1){mul_hi[MUL_A_W]}}, mul_hi};
   assign integ_new = sat_angle(integ_sum);

   // scale products end up in the high word plus the top bits of the low word
   assign mul_prod  = {mul_hi, mul_lo[MUL_B_W-1 -: SCALE_STEPS]};
   assign drive_sum = {pprod_ff[PROD_W-1], pprod_ff} + {mul_prod[PROD_W-1], mul_prod};
   assign drive     = sat_angle(drive_sum);

   assign mul_load = ctrl.take_in | ctrl.chk_commit | ctrl.d_end | ctrl.p_end;

   always_comb begin
      if (ctrl.take_in) begin
         mul_a = {{(MUL_A_W-ANGLE_W){e_in[ANGLE_W-1]}}, e_in};
         mul_b = kp;
      end else if (ctrl.chk_commit) begin
         mul_a = {{(MUL_A_W-ANGLE_W-1){d_diff[ANGLE_W]}}, d_diff};
         mul_b = kd;
      end else if (ctrl.d_end) begin
         mul_a = {{(MUL_A_W-ANGLE_W){integ_ff[ANGLE_W-1]}}, integ_ff};
         mul_b = {{(MUL_B_W-SCALE_W){1'b0}}, p_scale};
      end else begin
         mul_a = d_ff;
         mul_b = {{(MUL_B_W-SCALE_W){1'b0}}, d_scale};
      end
   end

   tapd_serial_mul #(
      .AW (MUL_A_W),
      .BW (MUL_B_W)
   ) u_mul (
      .clock (clock),
      .load  (mul_load),
      .step  (ctrl.mul_step),
      .a     (mul_a),
      .b     (mul_b),
      .hi    (mul_hi),
      .lo    (mul_lo)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         integ_ff    <= '0;
         last_err_ff <= '0;
      end else if (ctrl.clear) begin
         integ_ff    <= '0;
         last_err_ff <= '0;
      end else begin
         if (ctrl.chk_commit) begin
            integ_ff <= integ_new;
         end
         if (ctrl.d_end) begin
            last_err_ff <= err_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.take_in) begin
         err_ff <= e_in;
      end
      if (ctrl.d_end) begin
         d_ff <= mul_hi[MUL_A_W-1:0];
      end
      if (ctrl.p_end) begin
         pprod_ff <= mul_prod;
      end
   end

endmodule
`default_nettype wire

// ===== sv/tapd_ctrl.sv =====
`default_nettype none
module tapd_ctrl (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       req_valid,
   input  wire logic                       func,
   input  wire logic                       too_big_x,
   input  wire logic                       too_big_y,
   input  wire logic                       rsp_free,
   output      logic                       req_ready,
   output      tapd_pkg::ctrl_type         ctrl,
   output      logic                       out_load,
   output      tapd_pkg::result_kind_type  kind
);
   import tapd_pkg::*;

   state_type       state_ff, state_in;
   result_kind_type kind_ff, kind_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic            accept;
   logic            gain_last;
   logic            scale_last;
   logic            any_big;

   assign accept     = req_valid & (state_ff == ST_IDLE);
   assign gain_last  = cnt_ff == GAIN_LAST;
   assign scale_last = cnt_ff == SCALE_LAST;
   assign any_big    = too_big_x | too_big_y;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = (func == FUNC_CLEAR) ? ST_DONE : ST_P_MUL;
            end
         end
         ST_P_MUL: begin
            if (gain_last) state_in = ST_P_CHECK;
         end
         ST_P_CHECK: begin
            state_in = any_big ? ST_DONE : ST_D_MUL;
         end
         ST_D_MUL: begin
            if (gain_last) state_in = ST_D_END;
         end
         ST_D_END:  state_in = ST_SP_MUL;
         ST_SP_MUL: begin
            if (scale_last) state_in = ST_SP_END;
         end
         ST_SP_END: state_in = ST_SD_MUL;
         ST_SD_MUL: begin
            if (scale_last) state_in = ST_DONE;
         end
         ST_DONE: begin
            if (rsp_free) state_in = ST_IDLE;
         end
         default:   state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      ctrl      = '0;
      req_ready = 1'b0;
      out_load  = 1'b0;
      kind_in   = kind_ff;
      cnt_in    = '0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready       = 1'b1;
            ctrl.take_in    = accept & (func == FUNC_UPDATE);
            ctrl.clear      = accept & (func == FUNC_CLEAR);
            if (accept) begin
               kind_in = (func == FUNC_CLEAR) ? RES_CLEAR : RES_UPDATE;
            end
         end
         ST_P_MUL, ST_D_MUL: begin
            ctrl.mul_step = 1'b1;
            cnt_in        = gain_last ? '0 : cnt_ff + 1'b1;
         end
         ST_SP_MUL, ST_SD_MUL: begin
            ctrl.mul_step = 1'b1;
            cnt_in        = scale_last ? '0 : cnt_ff + 1'b1;
         end
         ST_P_CHECK: begin
            ctrl.chk_commit = ~any_big;
            if (any_big) kind_in = RES_TOO_FAST;
         end
         ST_D_END:  ctrl.d_end = 1'b1;
         ST_SP_END: ctrl.p_end = 1'b1;
         ST_DONE:   out_load   = rsp_free;
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         kind_ff  <= RES_UPDATE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         kind_ff  <= kind_in;
         cnt_ff   <= cnt_in;
      end
   end

   assign kind = kind_ff;

endmodule
`default_nettype wire

// ===== sv/two_axis_tilt_pd_controller.sv =====
`default_nettype none
// Channel   Direction  Payload
// -------   ---------  -------------------------------------------------------
// req_*     in         tdata: goal_x, goal_y, angle_x, angle_y; tuser: func
// rsp_*     out        tdata: drive_x, drive_y; tuser: too_fast
// csr_*     in         write enable, register index, write data (no read-back)
//
// An update item runs two passes of the bit-serial gain multiplier (kp, then
// kd) and two scale passes (p_scale, d_scale), with a check state after the kp
// pass, a state after each of the next two passes and a last state that loads
// the result register; the next item is taken from idle after that. Both axes
// run in lockstep, each on its own multiplier. A clear item skips the passes,
// and a too-fast item stops after the kp pass. One item is in flight at a time;
// a finished item holds while the output register is full, and the next item is
// taken while a result waits there. Reset is synchronous and returns the
// configuration registers to their reset values and the state to zero.
module two_axis_tilt_pd_controller (
   input  wire logic         clock,
   input  wire logic         reset,
   // request
   input  wire logic         req_tvalid,
   output      logic         req_tready,
   input  wire logic [127:0] req_tdata,   // goal_x, goal_y, angle_x, angle_y
   input  wire logic [0:0]   req_tuser,   // func
   // result
   output      logic         rsp_tvalid,
   input  wire logic         rsp_tready,
   output      logic [63:0]  rsp_tdata,   // drive_x, drive_y
   output      logic [0:0]   rsp_tuser,   // too_fast
   // configuration
   input  wire logic                             csr_we,
   input  wire logic [tapd_pkg::CSR_IDX_W-1:0]   csr_index,
   input  wire logic [tapd_pkg::CSR_W-1:0]       csr_wdata
);
   import tapd_pkg::*;

   // configuration registers
   logic [GAIN_W-1:0]  kp_x_ff, kp_y_ff, kd_x_ff, kd_y_ff;
   logic [LIMIT_W-1:0] step_limit_ff;
   logic [SCALE_W-1:0] p_scale_ff, d_scale_ff;

   // output register
   logic               rsp_valid_ff;
   logic [63:0]        rsp_data_ff;
   logic               rsp_user_ff;

   ctrl_type           ctrl;
   result_kind_type    kind;
   logic               out_load;
   logic               rsp_free;
   logic               too_big_x, too_big_y;
   logic signed [ANGLE_W-1:0] drive_x, drive_y;

   always_ff @(posedge clock) begin
      if (reset) begin
         kp_x_ff       <= KP_RESET;
         kp_y_ff       <= KP_RESET;
         kd_x_ff       <= KD_RESET;
         kd_y_ff       <= KD_RESET;
         step_limit_ff <= LIMIT_RESET;
         p_scale_ff    <= P_SC_RESET;
         d_scale_ff    <= D_SC_RESET;
      end else if (csr_we) begin
         // drop writes to unknown indexes
         unique case (csr_index)
            CSR_KP_X:       kp_x_ff       <= csr_wdata[GAIN_W-1:0];
            CSR_KP_Y:       kp_y_ff       <= csr_wdata[GAIN_W-1:0];
            CSR_KD_X:       kd_x_ff       <= csr_wdata[GAIN_W-1:0];
            CSR_KD_Y:       kd_y_ff       <= csr_wdata[GAIN_W-1:0];
            CSR_STEP_LIMIT: step_limit_ff <= csr_wdata[LIMIT_W-1:0];
            CSR_P_SCALE:    p_scale_ff    <= csr_wdata[SCALE_W-1:0];
            CSR_D_SCALE:    d_scale_ff    <= csr_wdata[SCALE_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // result register frees when empty or being taken this cycle
   assign rsp_free = ~rsp_valid_ff | rsp_tready;

   tapd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .func      (req_tuser[0]),
      .too_big_x (too_big_x),
      .too_big_y (too_big_y),
      .rsp_free  (rsp_free),
      .req_ready (req_tready),
      .ctrl      (ctrl),
      .out_load  (out_load),
      .kind      (kind)
   );

   tapd_axis u_axis_x (
      .clock      (clock),
      .reset      (reset),
      .ctrl       (ctrl),
      .goal       (req_tdata[31:0]),
      .angle      (req_tdata[95:64]),
      .kp         (kp_x_ff),
      .kd         (kd_x_ff),
      .step_limit (step_limit_ff),
      .p_scale    (p_scale_ff),
      .d_scale    (d_scale_ff),
      .too_big    (too_big_x),
      .drive      (drive_x)
   );

   tapd_axis u_axis_y (
      .clock      (clock),
      .reset      (reset),
      .ctrl       (ctrl),
      .goal       (req_tdata[63:32]),
      .angle      (req_tdata[127:96]),
      .kp         (kp_y_ff),
      .kd         (kd_y_ff),
      .step_limit (step_limit_ff),
      .p_scale    (p_scale_ff),
      .d_scale    (d_scale_ff),
      .too_big    (too_big_y),
      .drive      (drive_y)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   // zero drives for clear and too-fast items
   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_data_ff <= (kind == RES_UPDATE) ? {drive_y, drive_x} : '0;
         rsp_user_ff <= kind == RES_TOO_FAST;
      end
   end

   assign rsp_tvalid   = rsp_valid_ff;
   assign rsp_tdata    = rsp_data_ff;
   assign rsp_tuser[0] = rsp_user_ff;

endmodule
`default_nettype wire

// ===== sim/two_axis_tilt_pd_controller_tb.sv =====
`default_nettype none
module two_axis_tilt_pd_controller_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import tapd_pkg::*;

   localparam int CLOCK_HALF     = 4;
   localparam int RESET_CYCLES   = 8;
   localparam int DRAIN_CYCLES   = 64;        // a little more than the slowest item
   localparam int TIMEOUT_CYCLES = 1_000_000;
   localparam int REPORT_CAP     = 40;

   localparam longint S32_MAX = 64'sd2147483647;
   localparam longint S32_MIN = -64'sd2147483648;

   localparam logic signed [ANGLE_W-1:0] ANGLE_MAX = 32'h7FFF_FFFF;
   localparam logic signed [ANGLE_W-1:0] ANGLE_MIN = 32'h8000_0000;
   localparam int ONE_DEG = 65536;            // 1.0 in Q16.16

   // index with no register behind it; the block must drop writes to it
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE = 3'd7;

   typedef struct {
      logic                      func;
      logic signed [ANGLE_W-1:0] goal_x;
      logic signed [ANGLE_W-1:0] goal_y;
      logic signed [ANGLE_W-1:0] angle_x;
      logic signed [ANGLE_W-1:0] angle_y;
   } tilt_item_type;

   typedef struct {
      logic signed [ANGLE_W-1:0] drive_x;
      logic signed [ANGLE_W-1:0] drive_y;
      logic                      too_fast;
   } drive_result_type;

   // ------------------------------------------------------------------------
   // DUT hookup; every input starts at a known value
   // ------------------------------------------------------------------------
   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_tvalid = 1'b0;
   logic                 req_tready;
   logic [127:0]         req_tdata = '0;   // goal_x, goal_y, angle_x, angle_y
   logic [0:0]           req_tuser = '0;   // func
   logic                 rsp_tvalid;
   logic                 rsp_tready = 1'b0;
   logic [63:0]          rsp_tdata;        // drive_x, drive_y
   logic [0:0]           rsp_tuser;        // too_fast
   logic                 csr_we = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CSR_W-1:0]     csr_wdata = '0;

   two_axis_tilt_pd_controller dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always #(CLOCK_HALF) clock = ~clock;

   // ------------------------------------------------------------------------
   // Controller mirror: register copies and per-axis state
   // ------------------------------------------------------------------------
   longint gain_kp_x    = longint'(KP_RESET);
   longint gain_kp_y    = longint'(KP_RESET);
   longint gain_kd_x    = longint'(KD_RESET);
   longint gain_kd_y    = longint'(KD_RESET);
   longint step_limit_q = longint'(LIMIT_RESET);
   longint p_mult       = longint'(P_SC_RESET);
   longint d_mult       = longint'(D_SC_RESET);

   longint acc_x = 0, acc_y = 0;            // accumulated proportional steps
   longint prev_err_x = 0, prev_err_y = 0;  // errors of the last update past the limit check

   tilt_item_type    pending_q[$];          // items waiting to be sent
   drive_result_type expected_drive_q[$];   // drives owed by the block, oldest first
   tilt_item_type    item_on_bus;

   int unsigned send_idle_pct  = 0;
   int unsigned recv_stall_pct = 0;

   int error_count   = 0;
   int items_sent    = 0;
   int clears_sent   = 0;
   int results_seen  = 0;
   int too_fast_seen = 0;
   int cycle_count   = 0;

   function automatic longint clamp32(input longint v);
      if (v > S32_MAX) return S32_MAX;
      if (v < S32_MIN) return S32_MIN;
      return v;
   endfunction

   // append one item to the tail of the send queue
   function automatic void queue_tilt(input tilt_item_type it);
      pending_q.insert(pending_q.size(), it);
   endfunction

   // append one expectation to the tail of the scoreboard
   function automatic void owe_drive(input drive_result_type r);
      expected_drive_q.insert(expected_drive_q.size(), r);
   endfunction

   // Advance the mirror by one item and return the drives it owes.
   // Gain products are floor(x * gain / 2^16); >>> on a signed longint does that.
   function automatic drive_result_type predict_tilt(input tilt_item_type it);
      longint err_x, err_y, step_x, step_y, sum_x, sum_y, der_x, der_y;
      drive_result_type r;
      r.drive_x  = '0;
      r.drive_y  = '0;
      r.too_fast = 1'b0;
      if (it.func == FUNC_CLEAR) begin
         acc_x = 0;
         acc_y = 0;
         prev_err_x = 0;
         prev_err_y = 0;
         return r;
      end
      err_x  = clamp32(longint'(it.angle_x) - longint'(it.goal_x));
      err_y  = clamp32(longint'(it.angle_y) - longint'(it.goal_y));
      step_x = (err_x * gain_kp_x) >>> 16;
      step_y = (err_y * gain_kp_y) >>> 16;
      // a step over the limit on either axis freezes the state and zeroes both drives
      if (((step_x < 0) ? -step_x : step_x) > step_limit_q ||
          ((step_y < 0) ? -step_y : step_y) > step_limit_q) begin
         r.too_fast = 1'b1;
         return r;
      end
      sum_x = clamp32(acc_x + step_x);
      sum_y = clamp32(acc_y + step_y);
      // the error difference spans 33 bits; keep the derivative exact
      der_x = ((err_x - prev_err_x) * gain_kd_x) >>> 16;
      der_y = ((err_y - prev_err_y) * gain_kd_y) >>> 16;
      acc_x = sum_x;
      acc_y = sum_y;
      prev_err_x = err_x;
      prev_err_y = err_y;
      r.drive_x = 32'(clamp32(p_mult * sum_x + d_mult * der_x));
      r.drive_y = 32'(clamp32(p_mult * sum_y + d_mult * der_y));
      return r;
   endfunction

   // ------------------------------------------------------------------------
   // Stimulus helpers
   // ------------------------------------------------------------------------
   function automatic tilt_item_type make_tilt(input logic func,
                                               input logic signed [ANGLE_W-1:0] gx,
                                               input logic signed [ANGLE_W-1:0] gy,
                                               input logic signed [ANGLE_W-1:0] ax,
                                               input logic signed [ANGLE_W-1:0] ay);
      tilt_item_type it;
      it.func    = func;
      it.goal_x  = gx;
      it.goal_y  = gy;
      it.angle_x = ax;
      it.angle_y = ay;
      return it;
   endfunction

   function automatic logic signed [ANGLE_W-1:0] random_angle();
      case ($urandom_range(19))
         0: return ANGLE_MAX;
         1: return ANGLE_MIN;
         2: return '0;
         default: return $urandom;
      endcase
   endfunction

   // Pick an error whose step sits at or inside about the limit for this gain,
   // so most updates get past the limit check and move the accumulators.
   function automatic logic signed [ANGLE_W-1:0] bounded_error(input longint gain);
      longint span;
      span = (gain == 0) ? S32_MAX : ((step_limit_q + 1) <<< 16) / gain;
      if (span > S32_MAX) span = S32_MAX;
      if ($urandom_range(3) == 0) span = span >>> $urandom_range(24);
      span = longint'($urandom_range(32'(span)));
      return $urandom_range(1) ? 32'(-span) : 32'(span);
   endfunction

   // Mostly well-formed updates; the rest is clears and unbounded noise.
   function automatic tilt_item_type random_tilt();
      tilt_item_type it;
      int unsigned pick;
      pick = $urandom_range(99);
      it.func    = (pick < 5) ? FUNC_CLEAR : FUNC_UPDATE;
      it.angle_x = random_angle();
      it.angle_y = random_angle();
      if (pick < 15) begin
         it.goal_x = $urandom;
         it.goal_y = $urandom;
      end else begin
         it.goal_x = it.angle_x - bounded_error(gain_kp_x);
         it.goal_y = it.angle_y - bounded_error(gain_kp_y);
      end
      return it;
   endfunction

   task automatic report_mismatch(input string what);
      error_count++;
      if (error_count <= REPORT_CAP) $display("MISMATCH at %0t: %s", $time, what);
   endtask

   // Drive one register write and mirror it. Only called while the block is idle.
   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_W-1:0] data);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      case (idx)
         CSR_KP_X:       gain_kp_x    = longint'(data[GAIN_W-1:0]);
         CSR_KP_Y:       gain_kp_y    = longint'(data[GAIN_W-1:0]);
         CSR_KD_X:       gain_kd_x    = longint'(data[GAIN_W-1:0]);
         CSR_KD_Y:       gain_kd_y    = longint'(data[GAIN_W-1:0]);
         CSR_STEP_LIMIT: step_limit_q = longint'(data[LIMIT_W-1:0]);
         CSR_P_SCALE:    p_mult       = longint'(data[SCALE_W-1:0]);
         CSR_D_SCALE:    d_mult       = longint'(data[SCALE_W-1:0]);
         default: ;
      endcase
   endtask

   // Write every register back to back, then one to the spare index.
   // Upper data bits beyond each register's width are often set on purpose.
   task automatic apply_config(input int unsigned kpx, input int unsigned kpy,
                               input int unsigned kdx, input int unsigned kdy,
                               input int unsigned lim, input int unsigned ps,
                               input int unsigned ds);
      write_csr(CSR_KP_X, CSR_W'(kpx));
      write_csr(CSR_KP_Y, CSR_W'(kpy));
      write_csr(CSR_KD_X, CSR_W'(kdx));
      write_csr(CSR_KD_Y, CSR_W'(kdy));
      write_csr(CSR_STEP_LIMIT, CSR_W'(lim));
      write_csr(CSR_P_SCALE, CSR_W'(ps));
      write_csr(CSR_D_SCALE, CSR_W'(ds));
      write_csr(CSR_SPARE, CSR_W'($urandom));
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   // Hold until nothing is queued, on the bus or owed. Sample at the falling
   // edge so the driver's updates from the rising edge have settled.
   task automatic wait_idle();
      do @(negedge clock);
      while (pending_q.size() != 0 || expected_drive_q.size() != 0 || req_tvalid);
   endtask

   task automatic run_random(input int count);
      @(negedge clock);
      repeat (count) queue_tilt(random_tilt());
      wait_idle();
   endtask

   // ------------------------------------------------------------------------
   // Driver: predict on acceptance, then load the next item or idle
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            owe_drive(predict_tilt(item_on_bus));
            items_sent++;
            if (item_on_bus.func == FUNC_CLEAR) clears_sent++;
         end
         // the bus is free for a new item unless one is still waiting to be taken
         if (!req_tvalid || req_tready) begin
            if (pending_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               item_on_bus = pending_q.pop_front();
               req_tdata  <= {item_on_bus.angle_y, item_on_bus.angle_x,
                              item_on_bus.goal_y, item_on_bus.goal_x};
               req_tuser  <= item_on_bus.func;
               req_tvalid <= 1'b1;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // ------------------------------------------------------------------------
   // Monitor: check each taken result against the oldest expectation
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      drive_result_type want;
      logic signed [ANGLE_W-1:0] got_x, got_y;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got_x = rsp_tdata[31:0];
            got_y = rsp_tdata[63:32];
            results_seen++;
            if (rsp_tuser[0]) too_fast_seen++;
            if (expected_drive_q.size() == 0) begin
               report_mismatch($sformatf("unexpected result x=%h y=%h too_fast=%b",
                                         got_x, got_y, rsp_tuser[0]));
            end else begin
               want = expected_drive_q.pop_front();
               if (got_x !== want.drive_x)
                  report_mismatch($sformatf("result %0d drive_x got %h want %h",
                                            results_seen, got_x, want.drive_x));
               if (got_y !== want.drive_y)
                  report_mismatch($sformatf("result %0d drive_y got %h want %h",
                                            results_seen, got_y, want.drive_y));
               if (rsp_tuser[0] !== want.too_fast)
                  report_mismatch($sformatf("result %0d too_fast got %b want %b",
                                            results_seen, rsp_tuser[0], want.too_fast));
            end
         end
         rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // hard stop in case the block hangs
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == TIMEOUT_CYCLES) begin
         $display("Timeout after %0d cycles, %0d results still owed",
                  cycle_count, expected_drive_q.size());
         $display("*** FAILED ***");
         $finish;
      end
   end

   // ------------------------------------------------------------------------
   // Test sequence
   // ------------------------------------------------------------------------
   initial begin
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Reset gains: kp = 0.01, limit = 0.2, so errors near 20 deg sit on the limit.
      queue_tilt(make_tilt(FUNC_CLEAR, -1, -1, -1, -1));
      queue_tilt(make_tilt(FUNC_UPDATE, 0, 0, 0, 0));
      queue_tilt(make_tilt(FUNC_UPDATE, 0, 0, ONE_DEG, ONE_DEG));
      queue_tilt(make_tilt(FUNC_UPDATE, 0, 0, -5 * ONE_DEG, 3 * ONE_DEG));
      // just inside the limit on both axes, the negative one rounding down onto it
      queue_tilt(make_tilt(FUNC_UPDATE, 0, 0, 1311500, -1311400));
      // negative step one past the limit after rounding toward minus infinity
      queue_tilt(make_tilt(FUNC_UPDATE, 0, 0, -1311500, 0));
      // y alone over the limit
      queue_tilt(make_tilt(FUNC_UPDATE, 0, 0, 0, 1311600));
      // error overflow in both directions
      queue_tilt(make_tilt(FUNC_UPDATE, ANGLE_MIN, 0, ANGLE_MAX, 0));
      queue_tilt(make_tilt(FUNC_UPDATE, 0, ANGLE_MAX, 0, ANGLE_MIN));
      queue_tilt(make_tilt(FUNC_UPDATE, 0, 0, 2 * ONE_DEG, -2 * ONE_DEG));
      queue_tilt(make_tilt(FUNC_CLEAR, ANGLE_MAX, ANGLE_MIN, ANGLE_MAX, ANGLE_MIN));
      queue_tilt(make_tilt(FUNC_UPDATE, 0, 0, ONE_DEG, ONE_DEG));
      wait_idle();

      // Full-scale gains, no limit: drive the accumulators, drives and derivative
      // to their extremes.
      apply_config('1, '1, '1, '1, '1, '1, '1);
      @(negedge clock);
      repeat (3) queue_tilt(make_tilt(FUNC_UPDATE, ANGLE_MIN, ANGLE_MIN,
                                      ANGLE_MAX, ANGLE_MAX));
      repeat (2) queue_tilt(make_tilt(FUNC_UPDATE, ANGLE_MAX, ANGLE_MAX,
                                      ANGLE_MIN, ANGLE_MIN));
      queue_tilt(make_tilt(FUNC_UPDATE, 0, 0, 1, -1));
      queue_tilt(make_tilt(FUNC_UPDATE, ANGLE_MAX, ANGLE_MIN, ANGLE_MIN, ANGLE_MAX));
      queue_tilt(make_tilt(FUNC_CLEAR, -1, -1, -1, -1));
      queue_tilt(make_tilt(FUNC_UPDATE, 0, 0, -1, 1));
      queue_tilt(make_tilt(FUNC_UPDATE, -1, -1, 0, 0));
      wait_idle();

      // Random phases: each pairs a gain setting with an idle mix.
      send_idle_pct = 0;  recv_stall_pct = 0;
      apply_config(32'(KP_RESET), 32'(KP_RESET), 32'(KD_RESET), 32'(KD_RESET),
                   32'(LIMIT_RESET), 32'(P_SC_RESET), 32'(D_SC_RESET));
      run_random(160);

      send_idle_pct = 88; recv_stall_pct = 0;
      apply_config($urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
      run_random(160);

      // everything zero: steps and drives collapse to zero, limit of zero
      send_idle_pct = 0;  recv_stall_pct = 88;
      apply_config('0, '0, '0, '0, '0, '0, '0);
      run_random(120);

      send_idle_pct = 16; recv_stall_pct = 16;
      apply_config($urandom_range(4000), $urandom_range(4000), $urandom_range(65535),
                   $urandom_range(65535), $urandom_range(1 << 20), $urandom_range(16),
                   $urandom_range(255));
      run_random(160);

      send_idle_pct = 0;  recv_stall_pct = 0;
      apply_config('1, '1, '1, '1, '1, '1, '1);
      run_random(160);

      send_idle_pct = 16; recv_stall_pct = 16;
      apply_config($urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
      run_random(160);

      // strong gains against a tight limit: frequent too-fast items
      send_idle_pct = 0;  recv_stall_pct = 88;
      apply_config($urandom, $urandom, $urandom, $urandom, $urandom_range(1 << 16),
                   $urandom_range(255), $urandom_range(255));
      run_random(80);

      // let any stray result show up before the verdict
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Sent %0d items (%0d clears), checked %0d results, %0d of them too fast",
               items_sent, clears_sent, results_seen, too_fast_seen);
      $display("Covered reset, zero, full-scale and random gains under four idle mixes");
      if (error_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("%0d mismatches", error_count);
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
`default_nettype wire
